// File: design/cpdm_pkg.sv
package cpdm_pkg;

	// Channel and counter geometry
	localparam int NUM_CHANNELS = 8;
	localparam int CH_W = 3;
	localparam int COUNTER_BITS = 16;

	// Duty scale: hundredths of a percent
	localparam int DUTY_W = 14;
	localparam int DUTY_FULL = 10000;

	// Scaled numerator width and divider step counter width
	localparam int PROD_W = COUNTER_BITS + DUTY_W;
	localparam int STEP_W = $clog2(DUTY_W + 1);

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_CAP,
		S_WR_CH,
		S_WR_PART,
		S_RD_O,
		S_CHECK,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FIN
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic                    start;
		logic [PROD_W-1:0]       num;
		logic [COUNTER_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DUTY_W-1:0] quot;
	} div_rsp_t;

endpackage

// File: design/cpdm_div.sv
module cpdm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cpdm_pkg::div_req_t req,
	output cpdm_pkg::div_rsp_t rsp
);
	import cpdm_pkg::*;

	logic [COUNTER_BITS-1:0] rem_q;
	logic [COUNTER_BITS-1:0] den_q;
	logic [DUTY_W-1:0]       nq_q;
	logic [STEP_W-1:0]       cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [COUNTER_BITS:0]   shifted;
	logic [COUNTER_BITS:0]   trial;
	logic                    ge;

	// One restoring step: shift in next numerator bit, subtract if it fits.
	// Quotient is known to fit DUTY_W bits, so the top numerator bits seed the remainder.
	always_comb begin
		shifted = {rem_q, nq_q[DUTY_W-1]};
		ge      = shifted >= {1'b0, den_q};
		trial   = shifted - {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DUTY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and numerator/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[PROD_W-1:DUTY_W];
			nq_q  <= req.num[DUTY_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? trial[COUNTER_BITS-1:0] : shifted[COUNTER_BITS-1:0];
			nq_q  <= {nq_q[DUTY_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = nq_q;

endmodule

// File: design/capture_period_duty_meter.sv
// Capture period and duty meter.
// Each word passes the sequencer states (read capture, write channel, write partner, read
// other interval, check, divider start and wait, finish) around 14 steps of the shared radix-2
// divider, skipped when the duty is invalid; in_ready only in idle, so words do not overlap.
// Reset (arst_n low): link mode cleared, all stored captures and intervals read as zero.
module capture_period_duty_meter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [7:0]                           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [cpdm_pkg::CH_W-1:0]            channel,
	input  logic [cpdm_pkg::COUNTER_BITS-1:0]    capture_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [cpdm_pkg::CH_W-1:0]            out_channel,
	output logic [cpdm_pkg::COUNTER_BITS-1:0]    interval,
	output logic [cpdm_pkg::DUTY_W-1:0]          duty_hundredths,
	output logic                                 duty_valid
);
	import cpdm_pkg::*;

	state_t state_q, state_d;

	logic [7:0]              link_q;
	logic [CH_W-1:0]         ch_q;
	logic [COUNTER_BITS-1:0] cap_q;

	// Per-channel stores with valid bits
	logic [COUNTER_BITS-1:0] cap_mem [NUM_CHANNELS];
	logic [COUNTER_BITS-1:0] iv_mem  [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] cap_vld_q;
	logic [NUM_CHANNELS-1:0] iv_vld_q;

	logic [COUNTER_BITS-1:0] cap_rd_q;
	logic                    cap_rd_vld_q;
	logic [COUNTER_BITS-1:0] iv_rd_q;
	logic                    iv_rd_vld_q;

	logic [COUNTER_BITS-1:0] iv_q;
	logic [COUNTER_BITS-1:0] ie_q;
	logic [PROD_W-1:0]       prod_q;
	logic [COUNTER_BITS-1:0] den_q;
	logic [DUTY_W-1:0]       duty_q;
	logic                    dvalid_q;

	logic                    out_valid_q;
	logic [CH_W-1:0]         out_ch_q;
	logic [COUNTER_BITS-1:0] out_iv_q;
	logic [DUTY_W-1:0]       out_duty_q;
	logic                    out_dv_q;

	// Sequencer outputs
	logic                    cap_we;
	logic [CH_W-1:0]         cap_waddr;
	logic                    iv_we;
	logic [CH_W-1:0]         iv_raddr;
	logic                    out_load;

	// Derived values
	logic                    ch_ok, part_ok, pair_ok;
	logic [CH_W-1:0]         part_ch, e_ch, o_ch;
	logic [COUNTER_BITS-1:0] new_iv, io, mul_a, den_sel;
	logic                    mode_a, duty_ok;
	logic [PROD_W-1:0]       prod;

	div_req_t div_req;
	div_rsp_t div_rsp;

	cpdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Channel and pair decode
	always_comb begin
		part_ch = ch_q ^ CH_W'(1);
		e_ch    = {ch_q[CH_W-1:1], 1'b0};
		o_ch    = {ch_q[CH_W-1:1], 1'b1};
		ch_ok   = int'(ch_q) < NUM_CHANNELS;
		part_ok = int'(part_ch) < NUM_CHANNELS;
		pair_ok = int'(o_ch) < NUM_CHANNELS;
	end

	// Interval and duty arithmetic
	always_comb begin
		new_iv  = cap_q - (cap_rd_vld_q ? cap_rd_q : '0);
		io      = iv_rd_vld_q ? iv_rd_q : '0;
		mode_a  = link_q[e_ch] && !link_q[o_ch];
		duty_ok = pair_ok && (ie_q != '0) && (io != '0) &&
			(mode_a ? (io <= ie_q) : (ie_q <= io));
		mul_a   = mode_a ? io : io - ie_q;
		den_sel = mode_a ? ie_q : io;
		prod    = PROD_W'(mul_a) * PROD_W'(DUTY_FULL);
	end

	// Next state and sequencer outputs
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cap_we      = 1'b0;
		cap_waddr   = ch_q;
		iv_we       = 1'b0;
		iv_raddr    = o_ch;
		out_load    = 1'b0;
		div_req     = '0;
		div_req.num = prod_q;
		div_req.den = den_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = S_RD_CAP;
			end
			S_RD_CAP: begin
				state_d = ch_ok ? S_WR_CH : S_FIN;
			end
			S_WR_CH: begin
				cap_we  = 1'b1;
				iv_we   = 1'b1;
				state_d = S_WR_PART;
			end
			S_WR_PART: begin
				cap_we    = link_q[ch_q] && part_ok;
				cap_waddr = part_ch;
				iv_raddr  = e_ch;
				state_d   = S_RD_O;
			end
			S_RD_O: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = duty_ok ? S_DIV_GO : S_FIN;
			end
			S_DIV_GO: begin
				div_req.start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, link register and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			link_q    <= '0;
			cap_vld_q <= '0;
			iv_vld_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) link_q <= cfg_wdata;
			if (cap_we) cap_vld_q[cap_waddr] <= 1'b1;
			if (iv_we) iv_vld_q[ch_q] <= 1'b1;
		end
	end

	// Stores: one write and one registered read each per cycle
	always_ff @(posedge clk) begin
		if (cap_we) cap_mem[cap_waddr] <= cap_q;
		cap_rd_q     <= cap_mem[ch_q];
		cap_rd_vld_q <= cap_vld_q[ch_q];
	end

	always_ff @(posedge clk) begin
		if (iv_we) iv_mem[ch_q] <= new_iv;
		iv_rd_q     <= iv_mem[iv_raddr];
		iv_rd_vld_q <= iv_vld_q[iv_raddr];
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ch_q  <= channel;
				cap_q <= capture_value;
			end
			S_RD_CAP: begin
				iv_q     <= '0;
				duty_q   <= '0;
				dvalid_q <= 1'b0;
			end
			S_WR_CH: begin
				iv_q <= new_iv;
			end
			S_RD_O: begin
				ie_q <= iv_rd_vld_q ? iv_rd_q : '0;
			end
			S_CHECK: begin
				prod_q   <= prod;
				den_q    <= den_sel;
				duty_q   <= '0;
				dvalid_q <= duty_ok;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) duty_q <= div_rsp.quot;
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q   <= ch_q;
			out_iv_q   <= iv_q;
			out_duty_q <= duty_q;
			out_dv_q   <= dvalid_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_channel     = out_ch_q;
	assign interval        = out_iv_q;
	assign duty_hundredths = out_duty_q;
	assign duty_valid      = out_dv_q;

	// Checks
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && duty_valid |-> duty_hundredths <= DUTY_W'(DUTY_FULL))
		else $error("duty above full scale");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !duty_valid |-> duty_hundredths == '0)
		else $error("invalid duty not zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV_WAIT)
		else $error("divider done outside wait");

endmodule
